// ----- rtl/sha_pkg.sv -----
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int QueueDepth = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } eng_state_t;

  typedef logic [31:0] word_t;

  localparam word_t INITIAL_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic word_t ror32(word_t v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

// ----- rtl/sha_front.sv -----
module sha_front
  import sha_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_take,
  output in_item_t q_item
);

  localparam int AW = $clog2(DEPTH);

  in_item_t      mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  // idle items carry no work and are dropped here
  assign do_push = push && !full && (in_item.byte_valid || in_item.end_of_message);
  assign do_pop  = q_take && q_valid;
  assign full    = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ----- rtl/sha_engine.sv -----
module sha_engine
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_take,
  input  in_item_t  q_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  eng_state_t state, state_next;
  word_t       hash_words [8];
  word_t       v [8];
  word_t       blk [16];
  word_t       win [16];
  logic [63:0] bit_length;
  logic [5:0]  byte_offset;
  logic [5:0]  round_count;
  logic        padding;
  logic        end_seen;
  logic        final_blk;
  logic [2:0]  out_idx;

  word_t w15, w2, w7, w16, wnew, wcur, s1, ch, t1, s0, mj, t2;
  logic  fire_byte;
  logic  pad_byte;
  logic  [7:0] byte_in;
  logic  [4:0] sh;

  assign empty    = (state != ST_OUT);
  assign out_item = '{digest_word: hash_words[out_idx], word_index: out_idx,
                      last_word: (out_idx == 3'd7)};
  assign q_take   = (state == ST_IDLE) && q_valid;

  always_comb begin
    w15  = win[4'(round_count + 6'd1)];
    w2   = win[4'(round_count + 6'd14)];
    w7   = win[4'(round_count + 6'd9)];
    w16  = win[round_count[3:0]];
    wnew = w16 + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + w7
         + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
    wcur = (round_count < 6'd16) ? blk[round_count[3:0]] : wnew;
    s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + ROUND_K[round_count] + wcur;
    s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  always_comb begin
    fire_byte = q_take && q_item.byte_valid;
    pad_byte  = (state == ST_PAD) && !(byte_offset == LEN_OFFSET && padding);
    byte_in   = (state == ST_PAD) ? (padding ? 8'h00 : PAD_MARK) : q_item.data_byte;
    sh        = 5'd24 - {byte_offset[1:0], 3'b000};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_take) begin
          if (q_item.byte_valid && byte_offset == 6'd63) state_next = ST_ROUND;
          else if (q_item.end_of_message) state_next = ST_PAD;
        end
      end
      ST_ROUND: if (round_count == 6'd63) state_next = ST_ADD;
      ST_ADD: begin
        if (final_blk) state_next = ST_OUT;
        else if (end_seen) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_PAD: begin
        if (byte_offset == LEN_OFFSET && padding) state_next = ST_ROUND;
        else if (byte_offset == 6'd63) state_next = ST_ROUND;
      end
      ST_OUT: if (pop && out_idx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (fire_byte || pad_byte) begin
      blk[byte_offset[5:2]] <= (blk[byte_offset[5:2]] & ~(32'hff << sh))
                             | (word_t'(byte_in) << sh);
    end
    if (state == ST_PAD && byte_offset == LEN_OFFSET && padding) begin
      blk[14] <= bit_length[63:32];
      blk[15] <= bit_length[31:0];
    end
    if (state == ST_ROUND) begin
      win[round_count[3:0]] <= wcur;
    end else begin
      win <= blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_words  <= INITIAL_HASH;
      v           <= '{default: '0};
      bit_length  <= '0;
      byte_offset <= '0;
      round_count <= '0;
      padding     <= 1'b0;
      end_seen    <= 1'b0;
      final_blk   <= 1'b0;
      out_idx     <= '0;
    end else begin
      if (fire_byte) begin
        bit_length  <= bit_length + 64'd8;
        byte_offset <= byte_offset + 6'd1;
      end
      if (q_take && q_item.end_of_message) begin
        padding  <= 1'b0;
        end_seen <= 1'b1;
      end
      if (state == ST_PAD) begin
        if (byte_offset == LEN_OFFSET && padding) begin
          byte_offset <= '0;
          final_blk   <= 1'b1;
        end else begin
          byte_offset <= byte_offset + 6'd1;
          padding     <= 1'b1;
        end
      end
      if (state_next == ST_ROUND && state != ST_ROUND) begin
        v <= hash_words;
        round_count <= '0;
      end
      if (state == ST_ROUND) begin
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        round_count <= round_count + 6'd1;
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + v[i];
        round_count <= '0;
        if (final_blk) out_idx <= '0;
      end
      if (state == ST_OUT && pop) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          hash_words  <= INITIAL_HASH;
          v           <= '{default: '0};
          bit_length  <= '0;
          byte_offset <= '0;
          padding     <= 1'b0;
          end_seen    <= 1'b0;
          final_blk   <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/sha256_message_hasher.sv -----
// sha-256 digest of a byte stream
// input channel: push/full with data_byte, byte_valid, end_of_message;
// items with neither a byte nor an end mark are dropped at the front
// a front queue of four transactions feeds the compression engine
// each byte is taken while the engine is idle; every 64th byte starts the
// round and add states, and no further byte is taken until they finish
// an end transaction pads one byte per cycle to offset 56, then compresses;
// a second block is run when fewer than nine bytes remained free
// output channel: empty/pop, eight transactions of one digest word each,
// word_index 0 first, last_word set on the eighth
// while the receiver stalls the engine holds the digest and the queue
// keeps filling until full rises
// after the eighth word the engine returns to the initial hash values
// synchronous reset clears the queue and restores the initial state
module sha256_message_hasher
  import sha_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic     q_valid;
  logic     q_take;
  in_item_t q_item;

  sha_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst, .push, .full, .in_item, .q_valid, .q_take, .q_item
  );

  sha_engine u_engine (
    .clk, .rst, .q_valid, .q_take, .q_item, .empty, .pop, .out_item
  );

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.last_word == (out_item.word_index == 3'd7)))
    else $error("last_word mismatch");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item.word_index)))
    else $error("output changed while stalled");

  a_take: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("engine took from empty queue");

endmodule

// ----- tb/tb_sha256_message_hasher.sv -----
module tb_sha256_message_hasher;
  import sha_pkg::*;

  class digest_scoreboard;
    out_item_t pending_words[$];
    int mismatches;
    word_t hash_w[8];
    logic [7:0] msg_buf[64];
    logic [63:0] msg_bits;
    int fill;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      for (int i = 0; i < 8; i++) hash_w[i] = INITIAL_HASH[i];
      msg_bits = '0;
      fill = 0;
    endfunction

    function word_t rotr(word_t v, int s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void compress();
      word_t w[64];
      word_t a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
        w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
             + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      a = hash_w[0]; b = hash_w[1]; c = hash_w[2]; d = hash_w[3];
      e = hash_w[4]; f = hash_w[5]; g = hash_w[6]; h = hash_w[7];
      for (int r = 0; r < 64; r++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[r] + w[r];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_w[0] += a; hash_w[1] += b; hash_w[2] += c; hash_w[3] += d;
      hash_w[4] += e; hash_w[5] += f; hash_w[6] += g; hash_w[7] += h;
    endfunction

    function void add_byte(logic [7:0] v);
      msg_buf[fill] = v;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
    endfunction

    function void note_input(in_item_t it);
      logic [63:0] len;
      out_item_t o;
      if (it.byte_valid) begin
        msg_bits += 64'd8;
        add_byte(it.data_byte);
      end
      if (!it.end_of_message) return;
      len = msg_bits;
      add_byte(PAD_MARK);
      while (fill != int'(LEN_OFFSET)) add_byte(8'h00);
      for (int i = 0; i < 8; i++) msg_buf[56 + i] = len[63 - 8*i -: 8];
      fill = 0;
      compress();
      for (int k = 0; k < 8; k++) begin
        o.digest_word = hash_w[k];
        o.word_index = 3'(k);
        o.last_word = (k == 7);
        pending_words.insert(pending_words.size(), o);
      end
      clear_state();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp = pending_words.pop_front();
      if (got.digest_word !== exp.digest_word || got.word_index !== exp.word_index ||
          got.last_word !== exp.last_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                   exp.digest_word, exp.word_index, exp.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, push = 0, pop = 0;
  logic full, empty;
  in_item_t in_item = '0;
  out_item_t out_item;
  digest_scoreboard sb = new();
  bit calm = 0;
  bit hold_off = 0;
  int budget = 0;

  sha256_message_hasher dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always #5 clk = ~clk;

  task automatic send_item(logic [7:0] d, logic v, logic e);
    in_item_t it;
    it.data_byte = d; it.byte_valid = v; it.end_of_message = e;
    while (!calm && $urandom_range(99) < 6) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_message(int n, int mode);
    for (int i = 0; i < n; i++) begin
      case (mode)
        1: send_item(8'hff, 1, (i == n - 1));
        2: send_item(8'h00, 1, (i == n - 1));
        default: send_item(8'($urandom), 1, (i == n - 1));
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out_item);
    pop <= !hold_off && (calm || $urandom_range(99) >= 6);
  end

  // receiver stalls for a long stretch while the sender keeps going
  initial begin
    wait (budget > 170);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(8'h00, 0, 1);
    send_item(8'h5a, 0, 0);
    send_item(8'h61, 1, 1);
    send_message(3, 1);
    send_message(55, 0);
    send_message(56, 2);
    send_message(64, 0);
    send_item(8'h12, 1, 0);
    send_item(8'h00, 0, 0);
    send_item(8'h34, 0, 1);
    while (budget < 240) begin
      calm = (budget > 60 && budget < 150);
      n = ($urandom_range(3) == 0) ? $urandom_range(130) : $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) send_item(8'($urandom), 0, 0);
        send_item(8'($urandom), 1, 0);
      end
      send_item(8'($urandom), 1'($urandom_range(1)), 1);
      budget += n + 1;
    end
    calm = 0;
    push <= 0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ----- sha256_message_hasher.f -----
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_engine.sv
rtl/sha256_message_hasher.sv
tb/tb_sha256_message_hasher.sv
